>>> hdl/free_page_run_search_core_assert.svh
// Assertion shorthands; each expects clk and rst in the enclosing module.
`ifndef FREE_PAGE_RUN_SEARCH_CORE_ASSERT_SVH
`define FREE_PAGE_RUN_SEARCH_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FPRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FPRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fprs_pkg.sv
`default_nettype none
package fprs_pkg;

  localparam int PAGE_ENTRIES = 1024;
  localparam int PAGE_AW      = $clog2(PAGE_ENTRIES);
  localparam int START_W      = 10;
  localparam int COUNT_W      = 11;

  localparam logic [1:0] MODE_SEARCH    = 2'd0;
  localparam logic [1:0] MODE_MARK_USED = 2'd1;
  localparam logic [1:0] MODE_MARK_FREE = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [START_W-1:0] start_page;
    logic [COUNT_W-1:0] page_count;
  } cmd_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] run_start;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [PAGE_AW-1:0] waddr;
    logic               wdata;
    logic [PAGE_AW-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

>>> hdl/free_page_run_search_core.sv
`default_nettype none
// Channel  Dir  Beat content
// s_*      in   tuser: mode; tdata: start_page, page_count
// m_*      out  tuser: found; tdata: run_start
//
// After reset a clearing pass writes every page free, one page a cycle;
// s_tready stays low until it ends.
// A search reads one page bit per cycle from start_page upward through
// the page RAM, whose read port is registered.
// A mark writes one page per cycle, min(page_count, pages left) pages in all.
// One beat is worked at a time; a finished result waits in the output
// register, and the next beat is taken while it is held by m_tready low.
module free_page_run_search_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [9:0] start_page, [20:10] page_count, rest zero
  input  wire logic [1:0]  s_tuser,   // [1:0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [9:0] run_start, rest zero
  output logic             m_tuser    // [0] found
);
  import fprs_pkg::*;

  cmd_t     cmd;
  result_t  res;
  result_t  out_res;
  ram_req_t ram_req;
  logic     ram_rdata;
  logic     res_valid;
  logic     res_taken;

  // Unpack the command beat.
  assign cmd.mode       = s_tuser;
  assign cmd.start_page = s_tdata[START_W-1:0];
  assign cmd.page_count = s_tdata[START_W +: COUNT_W];

  // Load a finished result into the output register whenever it is empty or being drained.
  assign res_taken = res_valid && (!m_tvalid || m_tready);

  fprs_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_tvalid),
    .cmd_ready (s_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_taken (res_taken),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  fprs_page_ram #(
    .DEPTH (PAGE_ENTRIES),
    .AW    (PAGE_AW)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_taken) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Hold the result until the beat is taken.
  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.found;
  assign m_tdata = 16'(out_res.run_start);

endmodule
`default_nettype wire

>>> hdl/fprs_page_ram.sv
`default_nettype none
module fprs_page_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/fprs_walker.sv
`default_nettype none
`include "free_page_run_search_core_assert.svh"
module fprs_walker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire fprs_pkg::cmd_t     cmd,
  output logic                    res_valid,
  input  wire logic               res_taken,
  output fprs_pkg::result_t       res,
  output fprs_pkg::ram_req_t      ram_req,
  input  wire logic               ram_rdata
);
  import fprs_pkg::*;

  localparam logic [PAGE_AW-1:0] LAST_PAGE = PAGE_AW'(PAGE_ENTRIES - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_MARK  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t             state;
  logic [PAGE_AW:0]   cur;       // walk pointer, one bit wider to hold the table end
  logic [COUNT_W-1:0] remain;
  logic [COUNT_W-1:0] need;
  logic [COUNT_W-1:0] run;
  logic [PAGE_AW-1:0] begin_pg;
  logic               chk_vld;
  logic [PAGE_AW-1:0] chk_page;
  logic               mark_val;
  logic               cur_in_table;
  logic               start_out;
  logic [COUNT_W-1:0] run_inc;

  assign cur_in_table = 32'(cur) < PAGE_ENTRIES;
  assign start_out    = 32'(cmd.start_page) >= PAGE_ENTRIES;
  assign run_inc      = run + COUNT_W'(1);

  assign cmd_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = cur[PAGE_AW-1:0];
    ram_req.wdata = 1'b0;
    ram_req.raddr = cur[PAGE_AW-1:0];
    unique case (state)
      ST_CLEAR: ram_req.we = 1'b1;
      ST_MARK: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = mark_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      cur     <= '0;
      chk_vld <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (cur[PAGE_AW-1:0] == LAST_PAGE) begin
            state <= ST_IDLE;
          end else begin
            cur <= cur + 1'b1;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            res     <= '0;
            chk_vld <= 1'b0;
            run     <= '0;
            cur     <= (PAGE_AW + 1)'(cmd.start_page);
            remain  <= cmd.page_count;
            need    <= (cmd.page_count == '0) ? COUNT_W'(1) : cmd.page_count;
            state   <= ST_DONE;
            case (cmd.mode) inside
              MODE_SEARCH: begin
                if (!start_out) state <= ST_SCAN;
              end
              MODE_MARK_USED, MODE_MARK_FREE: begin
                mark_val <= (cmd.mode == MODE_MARK_USED);
                if (!start_out && cmd.page_count != '0) state <= ST_MARK;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          // Issue the next read while checking the bit that came back.
          chk_vld  <= cur_in_table;
          chk_page <= cur[PAGE_AW-1:0];
          if (cur_in_table) cur <= cur + 1'b1;
          if (chk_vld) begin
            if (ram_rdata) begin
              run <= '0;
            end else begin
              if (run == '0) begin_pg <= chk_page;
              run <= run_inc;
            end
            if (!ram_rdata && run_inc >= need) begin
              res.found     <= 1'b1;
              res.run_start <= START_W'((run == '0) ? chk_page : begin_pg);
              state         <= ST_DONE;
              chk_vld       <= 1'b0;
            end else if (chk_page == LAST_PAGE) begin
              state   <= ST_DONE;
              chk_vld <= 1'b0;
            end
          end
        end
        ST_MARK: begin
          if (remain == COUNT_W'(1) || cur[PAGE_AW-1:0] == LAST_PAGE) begin
            state <= ST_DONE;
          end else begin
            cur    <= cur + 1'b1;
            remain <= remain - 1'b1;
          end
        end
        ST_DONE: begin
          if (res_taken) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `FPRS_ASSERT_NOW(a_scan_no_write, state == ST_SCAN, !ram_req.we, "write during scan")
  `FPRS_ASSERT_NEXT(a_chk_from_scan, state != ST_SCAN, !chk_vld, "stray check outside scan")
  `FPRS_ASSERT_NOW(a_clear_blocks, state == ST_CLEAR, !cmd_ready && !res_valid,
                   "item taken during clearing pass")
  `FPRS_ASSERT_NOW(a_found_order,
                   res_valid && res.found && chk_vld == 1'b0 && state == ST_DONE,
                   32'(res.run_start) < PAGE_ENTRIES, "found run outside table")

endmodule
`default_nettype wire

>>> test/tb_free_page_run_search_core.sv
`default_nettype none
// Check the free page run search core against an in-bench model of the page table.
// Every accepted command beat queues one expected result. Every result beat is
// compared with the oldest one, field by field.
module tb_free_page_run_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fprs_pkg::*;

  // The mode field is two bits wide; the fourth code is a no-op that still answers.
  localparam logic [1:0] MODE_NOOP = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [9:0] start_page, [20:10] page_count, rest zero
  logic [1:0]  s_tuser = '0;   // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [9:0] run_start, rest zero
  logic        m_tuser;        // [0] found

  free_page_run_search_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Shadow page table, one busy bit per page, and the results still owed.
  bit      page_busy [PAGE_ENTRIES];
  result_t pending_runs [$];

  int err_count = 0;
  bit idle_on = 1'b1;        // random gaps on both sides while set
  int hold_req_count = 0;    // bump to ask the receiver for a long hold-off
  int hold_len = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s (got %0d, want %0d)", $realtime, what, got, want);
    err_count++;
  endtask

  // Apply one command to the shadow table and return the result it should give.
  function automatic result_t apply_page_cmd(input logic [1:0] mode,
                                             input logic [9:0] start,
                                             input logic [10:0] count);
    result_t r;
    int      need;
    int      run;
    int      first;
    int      stop;
    r = '0;
    case (mode) inside
      MODE_SEARCH: begin
        // Treat a zero count as one; a run cut off by the table end fails.
        need  = (count == 0) ? 1 : int'(count);
        run   = 0;
        first = 0;
        for (int p = int'(start); p < PAGE_ENTRIES && !r.found; p++) begin
          if (page_busy[p]) begin
            run = 0;
          end else begin
            if (run == 0) first = p;
            run++;
            if (run >= need) begin
              r.found     = 1'b1;
              r.run_start = first[9:0];
            end
          end
        end
      end
      MODE_MARK_USED, MODE_MARK_FREE: begin
        // Clip the range at the table end.
        stop = int'(start) + int'(count);
        if (stop > PAGE_ENTRIES) stop = PAGE_ENTRIES;
        for (int p = int'(start); p < stop; p++) page_busy[p] = (mode == MODE_MARK_USED);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one command beat, hold it until accepted, then queue its result.
  // Leave tvalid high on return so back-to-back beats go out without a gap.
  task automatic send_page_cmd(input logic [1:0] mode, input logic [9:0] start,
                               input logic [10:0] count);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {3'b000, count, start};
    do @(posedge clk); while (!s_tready);
    pending_runs.push_back(apply_page_cmd(mode, start, count));
  endtask

  // Mostly small counts so runs form and break often; a few huge ones hit clipping.
  task automatic send_random_cmd();
    logic [1:0]  mode;
    logic [9:0]  start;
    logic [10:0] count;
    int          pick;
    pick  = $urandom_range(0, 99);
    start = 10'($urandom_range(0, PAGE_ENTRIES - 1));
    if (pick < 45)      mode = MODE_SEARCH;
    else if (pick < 70) mode = MODE_MARK_USED;
    else if (pick < 95) mode = MODE_MARK_FREE;
    else                mode = MODE_NOOP;
    pick = $urandom_range(0, 99);
    if (pick < 5)       count = '0;
    else if (pick < 80) count = 11'($urandom_range(1, 24));
    else if (pick < 95) count = 11'($urandom_range(25, 300));
    else                count = 11'($urandom_range(301, 2047));
    send_page_cmd(mode, start, count);
  endtask

  // Result side: check each beat, then pick the next tready.
  always @(posedge clk) begin : result_side
    result_t want;
    int      stall_left;
    int      hold_left;
    int      hold_seen;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_runs.size() == 0) begin
        report_mismatch("result beat with nothing pending", int'(m_tdata[9:0]), -1);
      end else begin
        want = pending_runs.pop_front();
        if (m_tuser !== want.found)
          report_mismatch("found", int'(m_tuser), int'(want.found));
        if (m_tdata[9:0] !== want.run_start)
          report_mismatch("run_start", int'(m_tdata[9:0]), int'(want.run_start));
      end
    end
    // Start a long hold-off when asked; count it down here, cycle by cycle.
    if (hold_seen != hold_req_count) begin
      hold_seen = hold_req_count;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Walk the table edges and every special case once.
  task automatic test_directed();
    send_page_cmd(MODE_SEARCH,    10'd0,    11'd0);     // zero count acts as one
    send_page_cmd(MODE_SEARCH,    10'd0,    11'd1024);  // whole free table
    send_page_cmd(MODE_SEARCH,    10'd0,    11'd1025);  // longer than the table
    send_page_cmd(MODE_SEARCH,    10'd1023, 11'd1);     // last page alone
    send_page_cmd(MODE_SEARCH,    10'd1023, 11'd2);     // cut short at the end
    send_page_cmd(MODE_NOOP,      10'd1023, 11'd2047);
    send_page_cmd(MODE_MARK_USED, 10'd0,    11'd0);     // zero-length mark
    send_page_cmd(MODE_MARK_USED, 10'd1020, 11'd2047);  // clipped at the end
    send_page_cmd(MODE_SEARCH,    10'd1000, 11'd20);
    send_page_cmd(MODE_SEARCH,    10'd1000, 11'd21);
    send_page_cmd(MODE_MARK_USED, 10'd0,    11'd16);
    send_page_cmd(MODE_SEARCH,    10'd0,    11'd1);
    send_page_cmd(MODE_MARK_FREE, 10'd4,    11'd4);
    send_page_cmd(MODE_SEARCH,    10'd0,    11'd4);
    send_page_cmd(MODE_SEARCH,    10'd0,    11'd5);
    send_page_cmd(MODE_MARK_USED, 10'd100,  11'd1);
    send_page_cmd(MODE_SEARCH,    10'd90,   11'd20);
    send_page_cmd(MODE_SEARCH,    10'd0,    11'd2047);
    send_page_cmd(MODE_MARK_FREE, 10'd0,    11'd2047);
    send_page_cmd(MODE_MARK_USED, 10'd1023, 11'd1);
    send_page_cmd(MODE_SEARCH,    10'd0,    11'd1024);
    send_page_cmd(MODE_SEARCH,    10'd0,    11'd1023);
    send_page_cmd(MODE_NOOP,      10'd682,  11'd1365);  // alternate bits high in each field
    send_page_cmd(MODE_MARK_FREE, 10'd0,    11'd1024);
  endtask

  task automatic test_random_fragmented();
    repeat (500) send_random_cmd();
  endtask

  // Hold the result side off while beats keep coming so the core stalls its input.
  task automatic test_backpressure();
    hold_len = 600;
    hold_req_count++;
    repeat (10) send_page_cmd(MODE_SEARCH, 10'($urandom_range(0, 900)),
                              11'($urandom_range(0, 8)));
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    repeat (50) send_random_cmd();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_fragmented();
    test_backpressure();
    test_no_idle();
    s_tvalid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    // Give any stray extra beat time to show up.
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Bound the run: worst case is far below this even with every search walking the table.
  initial begin
    #60_000_000;
    $display("timeout with %0d results pending", pending_runs.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

>>> free_page_run_search_core.f
+incdir+hdl
hdl/fprs_pkg.sv
hdl/fprs_page_ram.sv
hdl/fprs_walker.sv
hdl/free_page_run_search_core.sv
test/tb_free_page_run_search_core.sv
